FILE: rtl/gtm_pkg.sv
// Shared types, constants and arithmetic helpers for the 4x3 GEMM tile.
// Used by gtm_mac_cell and gemm_tile_4x3_mac; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package gtm_pkg;

   localparam int DATA_W      = 16;   // Q1.15 operand width
   localparam int PROD_W      = 32;   // exact Q2.30 product width
   localparam int ACC_W       = 48;   // Q18.30 accumulator width
   localparam int MAX_ROWS    = 4;    // rows carried in every request item
   localparam int MAX_COLS    = 3;    // columns carried in every request item
   localparam int ROW_IDX_W   = 2;
   localparam int ROW_CNT_W   = 3;
   localparam int COL_CNT_W   = 2;
   localparam int REQ_TDATA_W = 264;
   localparam int RSP_TDATA_W = 152;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 3;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_UPDATE_MODE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROWS_USED   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_COLS_USED   = 2'd2;

   // Request kinds carried in req_tuser.
   localparam logic CMD_STEP  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // Per-cell control from the sequencing logic.
   typedef struct packed {
      logic acc_en;   // add this item's product into the cell
      logic clr;      // zero the cell (row flush)
   } cell_ctrl_type;

   // Signed addition that clamps to the 48-bit range instead of wrapping.
   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0] a,
      input logic signed [ACC_W-1:0] b
   );
      logic [ACC_W:0]          sum;
      logic signed [ACC_W-1:0] res;
      sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         res = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         res = sum[ACC_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/gtm_mac_cell.sv
// One accumulator of the tile: 16x16 signed multiply and saturating add.
// Depends on gtm_pkg for widths, the control struct and sat_add.
`timescale 1ns / 1ps
`default_nettype none

module gtm_mac_cell (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire gtm_pkg::cell_ctrl_type               ctrl,
   input  wire logic signed [gtm_pkg::DATA_W-1:0]    a_val,
   input  wire logic signed [gtm_pkg::DATA_W-1:0]    b_val,
   output      logic signed [gtm_pkg::ACC_W-1:0]     acc
);

   logic signed [gtm_pkg::PROD_W-1:0] prod;
   logic signed [gtm_pkg::ACC_W-1:0]  prod_ext;
   logic signed [gtm_pkg::ACC_W-1:0]  acc_ff;
   logic signed [gtm_pkg::ACC_W-1:0]  acc_in;

   // The Q2.30 product is taken as Q18.30 without any shift.
   assign prod     = a_val * b_val;
   assign prod_ext = {{(gtm_pkg::ACC_W-gtm_pkg::PROD_W){prod[gtm_pkg::PROD_W-1]}}, prod};

   always_comb begin
      acc_in = acc_ff;
      priority if (ctrl.clr) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = gtm_pkg::sat_add(acc_ff, prod_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

FILE: rtl/gemm_tile_4x3_mac.sv
// A flush item is held in the input register and then its result goes to the result register.
// Throughput: one item per cycle; all twelve MAC cells update in the same cycle. An item
// waits only behind a flush of an active row that finds the result register full
// while rsp_tready is low.
// Reset clears all accumulators, both valid flags, and sets update_mode = 0,
// rows_used = 4 and cols_used = 3.
// Top level of the GEMM tile: input register, MAC cell array, result register.
// Depends on gtm_pkg and gtm_mac_cell.
`timescale 1ns / 1ps
`default_nettype none

module gemm_tile_4x3_mac #(
   parameter int TILE_ROWS = 4,
   parameter int TILE_COLS = 3
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request channel.
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   // tdata: a_row0, a_row1, a_row2, a_row3, b_col0, b_col1, b_col2,
   //        old_c0, old_c1, old_c2, flush_row, zero fill.
   input  wire logic [gtm_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // tuser: command.
   input  wire logic                                 req_tuser,
   // Result channel.
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // tdata: out_row, new_c0, new_c1, new_c2, zero fill.
   output      logic [gtm_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // Configuration write port.
   input  wire logic                                 csr_we,
   input  wire logic [gtm_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  wire logic [gtm_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int DW = gtm_pkg::DATA_W;
   localparam int AW = gtm_pkg::ACC_W;
   localparam logic [gtm_pkg::ROW_CNT_W-1:0] ROWS_MAX = gtm_pkg::ROW_CNT_W'(TILE_ROWS);
   localparam logic [gtm_pkg::COL_CNT_W-1:0] COLS_MAX = gtm_pkg::COL_CNT_W'(TILE_COLS);

   // Configuration registers.
   logic                              update_mode_ff;
   logic [gtm_pkg::ROW_CNT_W-1:0]     rows_used_ff;
   logic [gtm_pkg::COL_CNT_W-1:0]     cols_used_ff;

   // Input register.
   logic                              in_vld_ff;
   logic                              in_vld_in;
   logic                              cmd_ff;
   logic signed [DW-1:0]              a_ff     [gtm_pkg::MAX_ROWS];
   logic signed [DW-1:0]              b_ff     [gtm_pkg::MAX_COLS];
   logic signed [AW-1:0]              old_c_ff [gtm_pkg::MAX_COLS];
   logic [gtm_pkg::ROW_IDX_W-1:0]     row_ff;

   // Result register.
   logic                              rsp_vld_ff;
   logic                              rsp_vld_in;
   logic [gtm_pkg::ROW_IDX_W-1:0]     rsp_row_ff;
   logic signed [AW-1:0]              rsp_c_ff [gtm_pkg::MAX_COLS];
   logic signed [AW-1:0]              rsp_c_in [gtm_pkg::MAX_COLS];

   logic                              in_fire;
   logic [gtm_pkg::ROW_CNT_W-1:0]     nrows;
   logic [gtm_pkg::COL_CNT_W-1:0]     ncols;
   logic                              flush_hit;
   logic                              emits;
   logic                              advance;

   logic signed [AW-1:0]              acc_q [TILE_ROWS][TILE_COLS];

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         update_mode_ff <= 1'b0;
         rows_used_ff   <= 3'd4;
         cols_used_ff   <= 2'd3;
      end else if (csr_we) begin
         unique case (csr_addr)
            gtm_pkg::CSR_UPDATE_MODE: update_mode_ff <= csr_wdata[0];
            gtm_pkg::CSR_ROWS_USED:   rows_used_ff   <= csr_wdata[gtm_pkg::ROW_CNT_W-1:0];
            gtm_pkg::CSR_COLS_USED:   cols_used_ff   <= csr_wdata[gtm_pkg::COL_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // A count of zero means one; a count past the tile size means the tile size.
   always_comb begin
      if (rows_used_ff == '0) begin
         nrows = gtm_pkg::ROW_CNT_W'(1);
      end else if (rows_used_ff > ROWS_MAX) begin
         nrows = ROWS_MAX;
      end else begin
         nrows = rows_used_ff;
      end
      if (cols_used_ff == '0) begin
         ncols = gtm_pkg::COL_CNT_W'(1);
      end else if (cols_used_ff > COLS_MAX) begin
         ncols = COLS_MAX;
      end else begin
         ncols = cols_used_ff;
      end
   end

   // ---------------- handshake ----------------
   assign in_fire    = req_tvalid && req_tready;
   assign flush_hit  = (cmd_ff == gtm_pkg::CMD_FLUSH) && ({1'b0, row_ff} < nrows);
   assign emits      = in_vld_ff && flush_hit;
   // A flush of an active row must find room in the result register.
   assign advance    = in_vld_ff && (!emits || !rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (in_fire) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         cmd_ff <= req_tuser;
         for (int r = 0; r < gtm_pkg::MAX_ROWS; r++) begin
            a_ff[r] <= req_tdata[r*DW +: DW];
         end
         for (int c = 0; c < gtm_pkg::MAX_COLS; c++) begin
            b_ff[c]     <= req_tdata[(gtm_pkg::MAX_ROWS + c)*DW +: DW];
            old_c_ff[c] <= req_tdata[(gtm_pkg::MAX_ROWS + gtm_pkg::MAX_COLS)*DW + c*AW +: AW];
         end
         row_ff <= req_tdata[(gtm_pkg::MAX_ROWS + gtm_pkg::MAX_COLS)*DW
                             + gtm_pkg::MAX_COLS*AW +: gtm_pkg::ROW_IDX_W];
      end
   end

   // ---------------- MAC cell array ----------------
   for (genvar gr = 0; gr < TILE_ROWS; gr++) begin : g_row
      for (genvar gc = 0; gc < TILE_COLS; gc++) begin : g_col
         gtm_pkg::cell_ctrl_type ctrl;

         assign ctrl.acc_en = advance && (cmd_ff == gtm_pkg::CMD_STEP)
                              && (gtm_pkg::ROW_CNT_W'(gr) < nrows)
                              && (gtm_pkg::COL_CNT_W'(gc) < ncols);
         // The flush clears every column of the row, active or not.
         assign ctrl.clr    = advance && flush_hit
                              && (row_ff == gtm_pkg::ROW_IDX_W'(gr));

         gtm_mac_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctrl  (ctrl),
            .a_val (a_ff[gr]),
            .b_val (b_ff[gc]),
            .acc   (acc_q[gr][gc])
         );
      end
   end

   // ---------------- result path ----------------
   for (genvar gc = 0; gc < gtm_pkg::MAX_COLS; gc++) begin : g_out
      if (gc < TILE_COLS) begin : g_live
         logic signed [AW-1:0] row_sel;

         always_comb begin
            row_sel = '0;
            for (int r = 0; r < TILE_ROWS; r++) begin
               if (row_ff == gtm_pkg::ROW_IDX_W'(r)) begin
                  row_sel = acc_q[r][gc];
               end
            end
         end

         always_comb begin
            rsp_c_in[gc] = '0;
            if (gtm_pkg::COL_CNT_W'(gc) < ncols) begin
               rsp_c_in[gc] = update_mode_ff ? gtm_pkg::sat_add(row_sel, old_c_ff[gc])
                                             : row_sel;
            end
         end
      end else begin : g_dead
         assign rsp_c_in[gc] = '0;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (emits && advance) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emits && advance) begin
         rsp_row_ff <= row_ff;
         for (int c = 0; c < gtm_pkg::MAX_COLS; c++) begin
            rsp_c_ff[c] <= rsp_c_in[c];
         end
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {
      {(gtm_pkg::RSP_TDATA_W - gtm_pkg::ROW_IDX_W - gtm_pkg::MAX_COLS*AW){1'b0}},
      rsp_c_ff[2], rsp_c_ff[1], rsp_c_ff[0], rsp_row_ff
   };

endmodule

`default_nettype wire
